// ===== rtl/core/rmq_pkg.sv =====
// Shared types, widths and codes for the rotation matrix to quaternion converter.
`default_nettype none
package rmq_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int FRAC_BITS    = 14;

    localparam int SW   = SAMPLE_WIDTH;
    localparam int AW   = SW + 3;                 // signed root argument
    localparam int RW   = (SW + FRAC_BITS + 3) / 2; // root bits
    localparam int RADW = 2 * RW;                 // radicand bits
    localparam int MAGW = SW + 1;                 // numerator magnitude
    localparam int DVW  = MAGW + FRAC_BITS + 1;   // dividend and quotient bits

    localparam int ONE_INT  = 1 << FRAC_BITS;
    localparam int SMAX_INT = (1 << (SW - 1)) - 1;

    // quaternion slots
    localparam logic [1:0] SLOT_W = 2'd0;
    localparam logic [1:0] SLOT_X = 2'd1;
    localparam logic [1:0] SLOT_Y = 2'd2;
    localparam logic [1:0] SLOT_Z = 2'd3;

    // largest diagonal axis
    localparam logic [1:0] AXIS_0 = 2'd0;
    localparam logic [1:0] AXIS_1 = 2'd1;
    localparam logic [1:0] AXIS_2 = 2'd2;

    typedef struct packed {
        logic signed [SW-1:0] m00;
        logic signed [SW-1:0] m01;
        logic signed [SW-1:0] m02;
        logic signed [SW-1:0] m10;
        logic signed [SW-1:0] m11;
        logic signed [SW-1:0] m12;
        logic signed [SW-1:0] m20;
        logic signed [SW-1:0] m21;
        logic signed [SW-1:0] m22;
    } in_t;

    typedef struct packed {
        logic signed [SW-1:0] quat_w;
        logic signed [SW-1:0] quat_x;
        logic signed [SW-1:0] quat_y;
        logic signed [SW-1:0] quat_z;
        logic                 degenerate;
    } out_t;

    // after the sqrt input stage
    typedef struct packed {
        logic                       deg;
        logic [1:0]                 rs;
        logic [2:0][1:0]            slot;
        logic [2:0]                 sign;
        logic [2:0][MAGW-1:0]       mag;
    } sq_side_t;

    // after the root is known
    typedef struct packed {
        logic                       deg;
        logic [1:0]                 rs;
        logic [2:0][1:0]            slot;
        logic [2:0]                 sign;
        logic [RW-1:0]              root;
    } dv_side_t;

    function automatic logic signed [AW-1:0] ext_a(input logic signed [SW-1:0] v);
        return {{(AW-SW){v[SW-1]}}, v};
    endfunction

    function automatic logic signed [MAGW-1:0] ext_n(input logic signed [SW-1:0] v);
        return {v[SW-1], v};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rmq_front.sv =====
// Front end: trace, pivot axis, root argument and signed numerators, two stages.
`default_nettype none
module rmq_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire logic               vld_i,
    input  wire rmq_pkg::in_t       mat_i,
    output logic                    vld_o,
    output logic [rmq_pkg::RADW-1:0] rad_o,
    output rmq_pkg::sq_side_t       side_o
);
    import rmq_pkg::*;

    logic                  v1_reg;
    in_t                   mat_reg;
    logic signed [AW-1:0]  trace_reg;
    logic                  tpos_reg;
    logic [1:0]            axis_reg;

    logic signed [AW-1:0]  trace_next;
    logic [1:0]            axis_next;
    logic signed [SW-1:0]  mi;

    logic                  v2_reg;
    logic [RADW-1:0]       rad_reg;
    sq_side_t              side_reg;

    logic signed [AW-1:0]  a;
    logic signed [MAGW-1:0] n [3];
    logic [RADW-1:0]       rad_next;
    sq_side_t              side_next;

    always_comb
    begin
        trace_next = ext_a(mat_i.m00) + ext_a(mat_i.m11) + ext_a(mat_i.m22);
        axis_next  = AXIS_0;
        mi         = mat_i.m00;
        if (mat_i.m11 > mat_i.m00)
        begin
            axis_next = AXIS_1;
            mi        = mat_i.m11;
        end
        if (mat_i.m22 > mi)
            axis_next = AXIS_2;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= vld_i;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mat_reg   <= mat_i;
            trace_reg <= trace_next;
            tpos_reg  <= (trace_next > 0);
            axis_reg  <= axis_next;
            rad_reg   <= rad_next;
            side_reg  <= side_next;
        end
    end

    always_comb
    begin
        side_next.rs   = SLOT_W;
        side_next.slot = {SLOT_Z, SLOT_Y, SLOT_X};
        a    = trace_reg + AW'(ONE_INT);
        n[0] = ext_n(mat_reg.m21) - ext_n(mat_reg.m12);
        n[1] = ext_n(mat_reg.m02) - ext_n(mat_reg.m20);
        n[2] = ext_n(mat_reg.m10) - ext_n(mat_reg.m01);
        if (!tpos_reg)
        begin
            unique case (axis_reg)
                AXIS_0:
                begin
                    a = ext_a(mat_reg.m00) - ext_a(mat_reg.m11) - ext_a(mat_reg.m22)
                        + AW'(ONE_INT);
                    side_next.rs   = SLOT_X;
                    n[0] = ext_n(mat_reg.m21) - ext_n(mat_reg.m12);
                    n[1] = ext_n(mat_reg.m10) + ext_n(mat_reg.m01);
                    n[2] = ext_n(mat_reg.m20) + ext_n(mat_reg.m02);
                    side_next.slot = {SLOT_Z, SLOT_Y, SLOT_W};
                end
                AXIS_1:
                begin
                    a = ext_a(mat_reg.m11) - ext_a(mat_reg.m22) - ext_a(mat_reg.m00)
                        + AW'(ONE_INT);
                    side_next.rs   = SLOT_Y;
                    n[0] = ext_n(mat_reg.m02) - ext_n(mat_reg.m20);
                    n[1] = ext_n(mat_reg.m21) + ext_n(mat_reg.m12);
                    n[2] = ext_n(mat_reg.m01) + ext_n(mat_reg.m10);
                    side_next.slot = {SLOT_X, SLOT_Z, SLOT_W};
                end
                default:
                begin
                    a = ext_a(mat_reg.m22) - ext_a(mat_reg.m00) - ext_a(mat_reg.m11)
                        + AW'(ONE_INT);
                    side_next.rs   = SLOT_Z;
                    n[0] = ext_n(mat_reg.m10) - ext_n(mat_reg.m01);
                    n[1] = ext_n(mat_reg.m02) + ext_n(mat_reg.m20);
                    n[2] = ext_n(mat_reg.m12) + ext_n(mat_reg.m21);
                    side_next.slot = {SLOT_Y, SLOT_X, SLOT_W};
                end
            endcase
        end
        side_next.deg = (a <= 0);
        for (int l = 0; l < 3; l++)
        begin
            side_next.sign[l] = n[l][MAGW-1];
            side_next.mag[l]  = n[l][MAGW-1] ? (~n[l] + 1'b1) : n[l];
        end
        // degenerate items run a zero radicand; their outputs are zeroed later
        rad_next = side_next.deg ? '0 : (RADW'(a[AW-2:0]) << FRAC_BITS);
    end

    assign vld_o  = v2_reg;
    assign rad_o  = rad_reg;
    assign side_o = side_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rmq_sqrt.sv =====
// Integer square root, one result bit per pipeline stage.
`default_nettype none
module rmq_sqrt (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                vld_i,
    input  wire logic [rmq_pkg::RADW-1:0] rad_i,
    input  wire rmq_pkg::sq_side_t   side_i,
    output logic                     vld_o,
    output logic [rmq_pkg::RW-1:0]   root_o,
    output rmq_pkg::sq_side_t        side_o
);
    import rmq_pkg::*;

    logic [RW-1:0]   vld_reg;
    logic [RW+1:0]   rem_reg  [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [RADW-1:0] rad_reg  [RW];
    sq_side_t        side_reg [RW];

    logic [RW+1:0]   rem_next  [RW];
    logic [RW-1:0]   root_next [RW];
    logic [RADW-1:0] rad_next  [RW];

    always_comb
    begin
        logic [RW+1:0]   pr_rem;
        logic [RW-1:0]   pr_root;
        logic [RADW-1:0] pr_rad;
        logic [RW+1:0]   rem_t;
        logic [RW+1:0]   trial;
        for (int s = 0; s < RW; s++)
        begin
            if (s == 0)
            begin
                pr_rem  = '0;
                pr_root = '0;
                pr_rad  = rad_i;
            end
            else
            begin
                pr_rem  = rem_reg[s-1];
                pr_root = root_reg[s-1];
                pr_rad  = rad_reg[s-1];
            end
            rem_t = {pr_rem[RW-1:0], pr_rad[RADW-1 -: 2]};
            trial = {pr_root, 2'b01};
            if (rem_t >= trial)
            begin
                rem_next[s]  = rem_t - trial;
                root_next[s] = {pr_root[RW-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = rem_t;
                root_next[s] = {pr_root[RW-2:0], 1'b0};
            end
            rad_next[s] = {pr_rad[RADW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[RW-2:0], vld_i};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < RW; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s]  <= rad_next[s];
                side_reg[s] <= (s == 0) ? side_i : side_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign vld_o  = vld_reg[RW-1];
    assign root_o = root_reg[RW-1];
    assign side_o = side_reg[RW-1];

endmodule
`default_nettype wire

// ===== rtl/core/rmq_div.sv =====
// Three-lane restoring divider, one quotient bit per stage, shared divisor 2*root.
`default_nettype none
module rmq_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic                vld_i,
    input  wire logic [rmq_pkg::RW-1:0] root_i,
    input  wire rmq_pkg::sq_side_t   side_i,
    output logic                     vld_o,
    output logic [2:0][rmq_pkg::DVW-1:0] quo_o,
    output rmq_pkg::dv_side_t        side_o
);
    import rmq_pkg::*;

    logic [DVW-1:0]            vld_reg;
    logic [2:0][RW+1:0]        rem_reg  [DVW];
    logic [2:0][DVW-1:0]       dvd_reg  [DVW];
    logic [2:0][DVW-1:0]       quo_reg  [DVW];
    dv_side_t                  side_reg [DVW];

    logic [2:0][RW+1:0]        rem_next [DVW];
    logic [2:0][DVW-1:0]       dvd_next [DVW];
    logic [2:0][DVW-1:0]       quo_next [DVW];
    dv_side_t                  side_in;

    always_comb
    begin
        side_in.deg  = side_i.deg;
        side_in.rs   = side_i.rs;
        side_in.slot = side_i.slot;
        side_in.sign = side_i.sign;
        side_in.root = root_i;
    end

    always_comb
    begin
        logic [RW+1:0]  pr_rem;
        logic [DVW-1:0] pr_dvd;
        logic [DVW-1:0] pr_quo;
        logic [RW:0]    divisor;
        logic [RW+1:0]  rem_t;
        for (int s = 0; s < DVW; s++)
        begin
            divisor = (s == 0) ? {root_i, 1'b0} : {side_reg[(s == 0) ? 0 : s-1].root, 1'b0};
            for (int l = 0; l < 3; l++)
            begin
                if (s == 0)
                begin
                    pr_rem = '0;
                    pr_quo = '0;
                    // rounding: (mag << F) + root, then divide by 2*root
                    pr_dvd = (DVW'(side_i.mag[l]) << FRAC_BITS) + DVW'(root_i);
                end
                else
                begin
                    pr_rem = rem_reg[s-1][l];
                    pr_quo = quo_reg[s-1][l];
                    pr_dvd = dvd_reg[s-1][l];
                end
                rem_t = {pr_rem[RW:0], pr_dvd[DVW-1]};
                if (rem_t >= {1'b0, divisor})
                begin
                    rem_next[s][l] = rem_t - {1'b0, divisor};
                    quo_next[s][l] = {pr_quo[DVW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[s][l] = rem_t;
                    quo_next[s][l] = {pr_quo[DVW-2:0], 1'b0};
                end
                dvd_next[s][l] = {pr_dvd[DVW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DVW-2:0], vld_i};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < DVW; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                dvd_reg[s]  <= dvd_next[s];
                quo_reg[s]  <= quo_next[s];
                side_reg[s] <= (s == 0) ? side_in : side_reg[(s == 0) ? 0 : s-1];
            end
        end
    end

    assign vld_o  = vld_reg[DVW-1];
    assign quo_o  = quo_reg[DVW-1];
    assign side_o = side_reg[DVW-1];

endmodule
`default_nettype wire

// ===== rtl/core/rotation_matrix_to_quaternion.sv =====
// Rotation matrix (Q2.14) to quaternion converter, fully pipelined.
//
// Input channel: in_valid / in_stall / in_data carries the nine matrix
// entries; a transfer happens on a rising edge with in_valid high and
// in_stall low. Output channel: out_valid / out_stall / out_data carries
// quat_w..quat_z and the degenerate flag, one result per input, in order.
// Pipeline: 2 front stages + RW root stages + DVW divide stages + 1 output
// register (RW = 16 and DVW = 32 at the default widths).
// Throughput: one matrix per cycle unless out_stall holds the pipeline; each root
// stage resolves one root bit, each divide stage one quotient bit for all three lanes at once.
// While a result sits on the output with out_stall high, the whole pipeline
// holds and in_stall is raised; nothing is dropped or repeated. The output
// register frees in the same cycle it is taken, so back-to-back transfers
// flow without bubbles.
// Reset (rst_n low, asynchronous) clears every valid bit; no result is
// pending afterward and, with in_stall low, the block accepts input straight away.
`default_nettype none
module rotation_matrix_to_quaternion (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire rmq_pkg::in_t  in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output rmq_pkg::out_t      out_data
);
    import rmq_pkg::*;

    logic                en;
    logic                f_vld;
    logic [RADW-1:0]     f_rad;
    sq_side_t            f_side;
    logic                s_vld;
    logic [RW-1:0]       s_root;
    sq_side_t            s_side;
    logic                d_vld;
    logic [2:0][DVW-1:0] d_quo;
    dv_side_t            d_side;

    logic                out_valid_reg;
    out_t                out_data_reg;
    out_t                out_data_next;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    rmq_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (in_valid),
        .mat_i  (in_data),
        .vld_o  (f_vld),
        .rad_o  (f_rad),
        .side_o (f_side)
    );

    rmq_sqrt u_sqrt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (f_vld),
        .rad_i  (f_rad),
        .side_i (f_side),
        .vld_o  (s_vld),
        .root_o (s_root),
        .side_o (s_side)
    );

    rmq_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .vld_i  (s_vld),
        .root_i (s_root),
        .side_i (s_side),
        .vld_o  (d_vld),
        .quo_o  (d_quo),
        .side_o (d_side)
    );

    always_comb
    begin
        logic signed [SW-1:0] comp [4];
        logic signed [SW-1:0] lane [3];
        logic signed [SW-1:0] half;
        logic [DVW-1:0]       hw;
        hw   = DVW'(d_side.root >> 1);
        half = (hw > DVW'(SMAX_INT)) ? SW'(SMAX_INT) : hw[SW-1:0];
        for (int l = 0; l < 3; l++)
        begin
            if (!d_side.sign[l])
                lane[l] = (d_quo[l] > DVW'(SMAX_INT)) ? SW'(SMAX_INT) : d_quo[l][SW-1:0];
            else if (d_quo[l] > DVW'(SMAX_INT + 1))
                lane[l] = {1'b1, {(SW-1){1'b0}}};
            else
                lane[l] = -d_quo[l][SW-1:0];
        end
        for (int t = 0; t < 4; t++)
        begin
            comp[t] = '0;
            if (d_side.rs == 2'(t))
                comp[t] = half;
            for (int l = 0; l < 3; l++)
                if (d_side.slot[l] == 2'(t))
                    comp[t] = lane[l];
            if (d_side.deg)
                comp[t] = '0;
        end
        out_data_next.quat_w     = comp[SLOT_W];
        out_data_next.quat_x     = comp[SLOT_X];
        out_data_next.quat_y     = comp[SLOT_Y];
        out_data_next.quat_z     = comp[SLOT_Z];
        out_data_next.degenerate = d_side.deg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== rtl/core/rmq_checker.sv =====
// Port-level checker for the quaternion converter, bound to the top level.
`default_nettype none
module rmq_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          in_stall,
    input  wire rmq_pkg::in_t  in_data,
    input  wire logic          out_valid,
    input  wire logic          out_stall,
    input  wire rmq_pkg::out_t out_data
);
    import rmq_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    // degenerate results carry a zero quaternion
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |->
            out_data.quat_w == '0 && out_data.quat_x == '0 &&
            out_data.quat_y == '0 && out_data.quat_z == '0)
        else $error("degenerate result not zero");

    // input is held back only by a blocked output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without output back-pressure");

    // a stalled input transfer keeps its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input changed while stalled");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the rotation matrix to quaternion converter.
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rmq_pkg::*;

    localparam int LATENCY = 51;
    localparam int HOLD_OFF_LEN = 300;
    localparam logic signed [SW-1:0] ONE_Q = SW'(ONE_INT);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off_cycles = 0;
    int mismatches = 0;
    out_t quat_expected[$];
    event hold_off_go;

    always #5 clk = ~clk;

    rotation_matrix_to_quaternion dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    function automatic longint isqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic longint clamp(longint v);
        if (v > SMAX_INT)
            return SMAX_INT;
        if (v < -SMAX_INT - 1)
            return -SMAX_INT - 1;
        return v;
    endfunction

    // n * 2^F / (2r), rounded half away from zero
    function automatic longint div_round(longint n, longint r);
        longint unsigned mag, q;
        mag = (n < 0) ? -n : n;
        q = ((mag << FRAC_BITS) + r) / (2 * r);
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic out_t to_quaternion(in_t d);
        longint m[3][3];
        longint q[4];
        longint tr, a, root;
        int i, j, k;
        out_t o;
        m[0][0] = d.m00; m[0][1] = d.m01; m[0][2] = d.m02;
        m[1][0] = d.m10; m[1][1] = d.m11; m[1][2] = d.m12;
        m[2][0] = d.m20; m[2][1] = d.m21; m[2][2] = d.m22;
        q = '{0, 0, 0, 0};
        o = '0;
        tr = m[0][0] + m[1][1] + m[2][2];
        if (tr > 0)
        begin
            root = isqrt((tr + ONE_INT) << FRAC_BITS);
            q[0] = clamp(root >> 1);
            q[1] = clamp(div_round(m[2][1] - m[1][2], root));
            q[2] = clamp(div_round(m[0][2] - m[2][0], root));
            q[3] = clamp(div_round(m[1][0] - m[0][1], root));
        end
        else
        begin
            i = 0;
            if (m[1][1] > m[0][0])
                i = 1;
            if (m[2][2] > m[i][i])
                i = 2;
            j = (i + 1) % 3;
            k = (j + 1) % 3;
            a = m[i][i] - m[j][j] - m[k][k] + ONE_INT;
            if (a <= 0)
                o.degenerate = 1'b1;
            else
            begin
                root = isqrt(a << FRAC_BITS);
                q[1 + i] = clamp(root >> 1);
                q[0] = clamp(div_round(m[k][j] - m[j][k], root));
                q[1 + j] = clamp(div_round(m[j][i] + m[i][j], root));
                q[1 + k] = clamp(div_round(m[k][i] + m[i][k], root));
            end
        end
        o.quat_w = q[0][SW-1:0];
        o.quat_x = q[1][SW-1:0];
        o.quat_y = q[2][SW-1:0];
        o.quat_z = q[3][SW-1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // in_valid stays high between back-to-back items; idling and drain lower it
    task automatic send_matrix(in_t d);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= d;
        quat_expected.push_back(to_quaternion(d));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(hold_off_go);
            for (int c = 0; c < HOLD_OFF_LEN; c++)
            begin
                hold_off_cycles <= HOLD_OFF_LEN - c;
                @(posedge clk);
            end
            hold_off_cycles <= 0;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
            out_stall <= 1'b1;
        else
            out_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        out_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (quat_expected.size() == 0)
                report_mismatch("extra transfer", 1, 0);
            else
            begin
                e = quat_expected.pop_front();
                if (out_data.quat_w !== e.quat_w)
                    report_mismatch("quat_w", out_data.quat_w, e.quat_w);
                if (out_data.quat_x !== e.quat_x)
                    report_mismatch("quat_x", out_data.quat_x, e.quat_x);
                if (out_data.quat_y !== e.quat_y)
                    report_mismatch("quat_y", out_data.quat_y, e.quat_y);
                if (out_data.quat_z !== e.quat_z)
                    report_mismatch("quat_z", out_data.quat_z, e.quat_z);
                if (out_data.degenerate !== e.degenerate)
                    report_mismatch("degenerate", out_data.degenerate, e.degenerate);
            end
        end
    end

    function automatic in_t rand_matrix();
        in_t d;
        logic [159:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
        d = bits[$bits(in_t)-1:0];
        return d;
    endfunction

    // near-diagonal matrices, each diagonal entry near +1 or -1 in a random sign, with small noise
    function automatic in_t rotation_like();
        in_t d;
        logic signed [SW-1:0] s[3];
        int n;
        d = '0;
        foreach (s[t])
            s[t] = $urandom_range(1) ? ONE_Q : -ONE_Q;
        d.m00 = SW'(int'(s[0]) + int'($urandom_range(4000)) - 2000);
        d.m11 = SW'(int'(s[1]) + int'($urandom_range(4000)) - 2000);
        d.m22 = SW'(int'(s[2]) + int'($urandom_range(4000)) - 2000);
        n = $urandom_range(12000);
        d.m01 = SW'(int'($urandom_range(n)) - n / 2);
        d.m02 = SW'(int'($urandom_range(n)) - n / 2);
        d.m10 = SW'(int'($urandom_range(n)) - n / 2);
        d.m12 = SW'(int'($urandom_range(n)) - n / 2);
        d.m20 = SW'(int'($urandom_range(n)) - n / 2);
        d.m21 = SW'(int'($urandom_range(n)) - n / 2);
        return d;
    endfunction

    task automatic drain();
        in_valid <= 1'b0;
        while (quat_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic test_directed();
        in_t d;
        d = '0; d.m00 = ONE_Q; d.m11 = ONE_Q; d.m22 = ONE_Q;
        send_matrix(d);                       // identity, positive trace
        d = '0; d.m00 = ONE_Q; d.m11 = -ONE_Q; d.m22 = -ONE_Q;
        send_matrix(d);                       // 180 deg about x
        d = '0; d.m00 = -ONE_Q; d.m11 = ONE_Q; d.m22 = -ONE_Q;
        send_matrix(d);
        d = '0; d.m00 = -ONE_Q; d.m11 = -ONE_Q; d.m22 = ONE_Q;
        send_matrix(d);
        d = '0; d.m00 = -ONE_Q; d.m11 = -ONE_Q; d.m22 = -ONE_Q;
        send_matrix(d);                       // tie, lower index wins
        d = '0;
        send_matrix(d);                       // zero matrix, trace zero
        d = '0; d.m00 = -ONE_Q; d.m11 = ONE_Q; d.m22 = ONE_Q;
        send_matrix(d);                       // positive trace despite negative m00
        d = '0; d.m11 = 16'sh7fff; d.m22 = 16'sh7fff; d.m00 = -16'sh7fff;
        send_matrix(d);
        d = '{default: 16'sh7fff};
        send_matrix(d);                       // max everything
        d = '{default: 16'sh8000};
        send_matrix(d);                       // min everything, three-way tie
        d = '{default: 16'sh8000}; d.m00 = 16'sh7fff;
        send_matrix(d);                       // saturating sums
        d = '0; d.m00 = 16'sd1; d.m12 = 16'sh7fff; d.m21 = 16'sh8000;
        send_matrix(d);                       // tiny trace, huge difference
        d = '0; d.m00 = -ONE_Q; d.m11 = 16'sd0; d.m22 = 16'sd0;
        send_matrix(d);                       // negative trace, tie between 1 and 2
        d = '0; d.m22 = 16'sd1; d.m00 = -16'sd1;
        send_matrix(d);                       // trace zero, axis 2
        d = '{default: 16'sh7fff}; d.m00 = 16'sh8000; d.m11 = 16'sh8000;
        send_matrix(d);
        d = '{default: 16'shffff};
        send_matrix(d);
        d = '{default: 16'sh5555};
        send_matrix(d);
        d = '{default: 16'shaaaa};
        send_matrix(d);
        drain();
    endtask

    task automatic test_random(int count, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (count)
        begin
            if ($urandom_range(99) < 75)
                send_matrix(rotation_like());
            else
                send_matrix(rand_matrix());
        end
        drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        -> hold_off_go;
        repeat (200) send_matrix(rotation_like());
        drain();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(450, 0, 0);
        test_random(450, 49, 0);
        test_random(450, 0, 49);
        test_random(450, 22, 22);
        test_backpressure();
        if (mismatches == 0 && quat_expected.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
